FILE: rtl/ppbm_pkg.sv
// Package for the ping-pong buffer manager: codes, defaults and the result record.
`default_nettype none

package ppbm_pkg;

  localparam int unsigned BufferBytesDefault = 65536;
  localparam int unsigned ThresholdW         = 17;
  localparam logic [ThresholdW-1:0] ThresholdReset = 17'd61440;
  localparam int unsigned ApbDataW           = 32;
  localparam int unsigned PaddrW             = 3;
  localparam int unsigned SeqW               = 64;
  localparam int unsigned OffsetW            = 16;
  localparam int unsigned FillOutW           = 17;

  // Register word index, taken from paddr[2].
  localparam logic CfgIdxThreshold = 1'b0;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhFilling = 3'd1,
    PhReady   = 3'd2,
    PhWriting = 3'd3,
    PhSyncing = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StTooLarge   = 3'd1,
    StBusy       = 3'd2,
    StRetry      = 3'd3,
    StNoneReady  = 3'd4,
    StWrongState = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    KindAcquire   = 3'd0,
    KindFlush     = 3'd1,
    KindClaim     = 3'd2,
    KindWriteDone = 3'd3,
    KindRelease   = 3'd4,
    KindSwitch    = 3'd5
  } kind_e;

  typedef struct packed {
    status_e               status;
    logic [OffsetW-1:0]    byte_offset;
    logic                  buffer_index;
    logic [FillOutW-1:0]   active_fill;
    logic [SeqW-1:0]       active_sequence;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ping_pong_buffer_manager_top.sv
// Ping-pong buffer manager: two buffers shared by a producer and a flushing consumer.
//
// Input channel (in_valid_i / in_stall_o) carries one operation per transaction:
// kind_i, request_bytes_i, buffer_select_i. Output channel (out_valid_o /
// out_stall_i) returns exactly one result transaction per operation.
// A transaction moves when valid is high and stall is low at a rising edge.
// State updates at the accepting edge, and the result is loaded into the output
// register at that same edge. Throughput is one operation per cycle while the
// receiver does not stall, set by the single result register behind the
// combinational step logic.
// When the receiver stalls, the result holds and in_stall_o rises only while
// the output register is full and stalled; otherwise input is taken every cycle.
// Reset (rst_ni low, asynchronous) puts both buffers in idle with zero fill and
// sequence, selects buffer zero, sets flush_threshold to 61440 and empties the
// output register. No clearing pass is needed.
// The APB port holds flush_threshold at byte address 0; pready is always high.
`default_nettype none

module ping_pong_buffer_manager_top
  import ppbm_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // operation channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [16:0]         request_bytes_i,
  input  logic                buffer_select_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [OffsetW-1:0]  byte_offset_o,
  output logic                buffer_index_o,
  output logic [FillOutW-1:0] active_fill_o,
  output logic [SeqW-1:0]     active_sequence_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned FillW = $clog2(BUFFER_BYTES + 1);

  logic [ThresholdW-1:0] threshold_q;
  phase_e                phase_q [2];
  phase_e                phase_d [2];
  logic [FillW-1:0]      fill_q [2];
  logic [FillW-1:0]      fill_d [2];
  logic [SeqW-1:0]       seq_q [2];
  logic [SeqW-1:0]       seq_d [2];
  logic [SeqW-1:0]       next_seq_q;
  logic [SeqW-1:0]       next_seq_d;
  logic                  active_q;
  logic                  active_d;
  result_t               result_d;
  result_t               result_q;
  logic                  out_valid_q;
  logic                  in_accept;
  logic                  cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == CfgIdxThreshold) ? ApbDataW'(threshold_q) : '0;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_write && paddr[2] == CfgIdxThreshold) begin
      threshold_q <= pwdata[ThresholdW-1:0];
    end
  end

  ppbm_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .buffer_select_i (buffer_select_i),
    .threshold_i     (threshold_q),
    .phase_q_i       (phase_q),
    .fill_q_i        (fill_q),
    .seq_q_i         (seq_q),
    .next_seq_q_i    (next_seq_q),
    .active_q_i      (active_q),
    .phase_d_o       (phase_d),
    .fill_d_o        (fill_d),
    .seq_d_o         (seq_d),
    .next_seq_d_o    (next_seq_d),
    .active_d_o      (active_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '{PhIdle, PhIdle};
      fill_q     <= '{'0, '0};
      seq_q      <= '{'0, '0};
      next_seq_q <= '0;
      active_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      seq_q      <= seq_d;
      next_seq_q <= next_seq_d;
      active_q   <= active_d;
    end
  end

  // Output register: load on accept, drop once the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = result_q.status;
  assign byte_offset_o     = result_q.byte_offset;
  assign buffer_index_o    = result_q.buffer_index;
  assign active_fill_o     = result_q.active_fill;
  assign active_sequence_o = result_q.active_sequence;

endmodule

`default_nettype wire

FILE: rtl/ppbm_step.sv
// Next-state and result logic for one ping-pong buffer transaction.
`default_nettype none

module ppbm_step
  import ppbm_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytesDefault,
  localparam int unsigned FillW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic [2:0]            kind_i,
  input  logic [16:0]           request_bytes_i,
  input  logic                  buffer_select_i,
  input  logic [ThresholdW-1:0] threshold_i,
  input  phase_e                phase_q_i [2],
  input  logic [FillW-1:0]      fill_q_i [2],
  input  logic [SeqW-1:0]       seq_q_i [2],
  input  logic [SeqW-1:0]       next_seq_q_i,
  input  logic                  active_q_i,
  output phase_e                phase_d_o [2],
  output logic [FillW-1:0]      fill_d_o [2],
  output logic [SeqW-1:0]       seq_d_o [2],
  output logic [SeqW-1:0]       next_seq_d_o,
  output logic                  active_d_o,
  output result_t               result_o
);

  localparam int unsigned CmpW = ((FillW > ThresholdW) ? FillW : ThresholdW) + 1;
  localparam logic [CmpW-1:0] BufBytes = CmpW'(BUFFER_BYTES);

  logic            cur;
  logic            nxt;
  logic [CmpW-1:0] thr_ext;
  logic [CmpW-1:0] thr_eff;
  logic [CmpW-1:0] req_ext;
  logic [CmpW-1:0] sum;
  logic            take_other;
  logic            claimed;
  logic            claim_idx;
  status_e         status;
  logic [OffsetW-1:0] offset;

  assign cur     = active_q_i;
  assign nxt     = ~active_q_i;
  assign thr_ext = CmpW'(threshold_i);
  assign thr_eff = (thr_ext > BufBytes) ? BufBytes : thr_ext;
  assign req_ext = CmpW'(request_bytes_i);
  assign sum     = CmpW'(fill_q_i[cur]) + req_ext;

  always_comb begin
    phase_d_o    = phase_q_i;
    fill_d_o     = fill_q_i;
    seq_d_o      = seq_q_i;
    next_seq_d_o = next_seq_q_i;
    active_d_o   = active_q_i;
    status       = StOk;
    offset       = '0;
    claimed      = 1'b0;
    claim_idx    = 1'b0;
    take_other   = 1'b0;

    unique case (kind_i)
      KindAcquire: begin
        if (req_ext > BufBytes) begin
          status = StTooLarge;
        end else if (phase_q_i[cur] != PhIdle && phase_q_i[cur] != PhFilling) begin
          status = StBusy;
        end else if (sum > thr_eff) begin
          // Mark full and try to hand over; retry is answered either way.
          phase_d_o[cur] = PhReady;
          take_other     = (phase_q_i[nxt] == PhIdle);
          status         = StRetry;
        end else begin
          phase_d_o[cur] = PhFilling;
          offset         = OffsetW'(fill_q_i[cur]);
          fill_d_o[cur]  = FillW'(sum);
        end
      end
      KindFlush: begin
        if (fill_q_i[cur] != '0) begin
          if (phase_q_i[cur] == PhFilling) begin
            phase_d_o[cur] = PhReady;
          end else begin
            status = StWrongState;
          end
        end
      end
      KindClaim: begin
        priority if (phase_q_i[0] == PhReady) begin
          claimed   = 1'b1;
          claim_idx = 1'b0;
        end else if (phase_q_i[1] == PhReady) begin
          claimed   = 1'b1;
          claim_idx = 1'b1;
        end else begin
          status = StNoneReady;
        end
        if (claimed) begin
          phase_d_o[claim_idx] = PhWriting;
        end
      end
      KindWriteDone: begin
        if (phase_q_i[buffer_select_i] == PhWriting) begin
          phase_d_o[buffer_select_i] = PhSyncing;
        end else begin
          status = StWrongState;
        end
      end
      KindRelease: begin
        if (phase_q_i[buffer_select_i] == PhSyncing) begin
          phase_d_o[buffer_select_i] = PhIdle;
          fill_d_o[buffer_select_i]  = '0;
        end else begin
          status = StWrongState;
        end
      end
      KindSwitch: begin
        if (phase_q_i[cur] == PhIdle) begin
          status = StWrongState;
        end else begin
          if (phase_q_i[cur] == PhFilling) begin
            phase_d_o[cur] = PhReady;
          end
          if (phase_q_i[nxt] == PhIdle) begin
            take_other = 1'b1;
          end else begin
            status = StBusy;
          end
        end
      end
      default: begin
        status = StWrongState;
      end
    endcase

    // Activate the other buffer and stamp it with the next sequence number.
    if (take_other) begin
      phase_d_o[nxt] = PhFilling;
      active_d_o     = nxt;
      seq_d_o[nxt]   = next_seq_q_i;
      next_seq_d_o   = next_seq_q_i + SeqW'(1);
    end
  end

  always_comb begin
    result_o.status          = status;
    result_o.byte_offset     = offset;
    result_o.buffer_index    = claimed ? claim_idx : active_d_o;
    result_o.active_fill     = FillOutW'(fill_d_o[active_d_o]);
    result_o.active_sequence = seq_d_o[active_d_o];
  end

endmodule

`default_nettype wire

FILE: rtl/ppbm_checker.sv
// Port-level assertions for the ping-pong buffer manager, bound to the top level.
`default_nettype none

module ppbm_checker
  import ppbm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [2:0]          status_o,
  input wire logic [OffsetW-1:0]  byte_offset_o,
  input wire logic [SeqW-1:0]     active_sequence_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(byte_offset_o) && $stable(active_sequence_o))
    else $error("stalled result changed or dropped");

  // Input is held off only behind a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Every accepted transaction shows a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // A nonzero offset comes only from a successful acquire.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_offset_o != '0 |-> status_o == StOk)
    else $error("offset reported on a failed operation");

endmodule

bind ping_pong_buffer_manager_top ppbm_checker u_ppbm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .byte_offset_o     (byte_offset_o),
  .active_sequence_o (active_sequence_o)
);

`default_nettype wire

FILE: tb/ppbm_scoreboard.sv
// Scoreboard for the ping-pong buffer manager: buffer state predictor and result checker.
package ppbm_tb_pkg;
  import ppbm_pkg::*;

  class buffer_scoreboard;
    logic [ThresholdW-1:0] threshold;
    phase_e                phase [2];
    logic [FillOutW-1:0]   fill [2];
    logic [SeqW-1:0]       stamp [2];
    logic [SeqW-1:0]       next_stamp;
    logic                  active;
    result_t               owed_replies [$];
    int                    mismatches;
    int                    noted;
    int                    checked;

    function new();
      threshold  = ThresholdReset;
      foreach (phase[i]) begin
        phase[i] = PhIdle;
        fill[i]  = '0;
        stamp[i] = '0;
      end
      next_stamp = '0;
      active     = 1'b0;
      mismatches = 0;
      noted      = 0;
      checked    = 0;
    endfunction

    function void set_threshold(logic [ThresholdW-1:0] value);
      threshold = value;
    endfunction

    // Retire the active buffer and move to the other one if it is free.
    function status_e try_switch();
      logic nxt;
      nxt = ~active;
      if (phase[active] == PhFilling) phase[active] = PhReady;
      else if (phase[active] == PhIdle) return StWrongState;
      if (phase[nxt] != PhIdle) return StBusy;
      phase[nxt] = PhFilling;
      active     = nxt;
      stamp[nxt] = next_stamp;
      next_stamp = next_stamp + 1'b1;
      return StOk;
    endfunction

    function result_t step_buffers(logic [2:0] kind, logic [16:0] req, logic sel);
      result_t     r;
      int unsigned limit;
      int unsigned offset;
      logic        claimed;
      logic        claim_idx;
      r.status  = StOk;
      offset    = 0;
      claimed   = 1'b0;
      claim_idx = 1'b0;
      case (kind)
        KindAcquire: begin
          limit = (threshold > BufferBytesDefault) ? BufferBytesDefault : 32'(threshold);
          if (req > BufferBytesDefault) begin
            r.status = StTooLarge;
          end else begin
            if (phase[active] == PhIdle) phase[active] = PhFilling;
            if (phase[active] != PhFilling) begin
              r.status = StBusy;
            end else if (fill[active] + req > limit) begin
              void'(try_switch());
              r.status = StRetry;
            end else begin
              offset       = 32'(fill[active]);
              fill[active] = fill[active] + req;
            end
          end
        end
        KindFlush: begin
          if (fill[active] != '0) begin
            if (phase[active] == PhFilling) phase[active] = PhReady;
            else r.status = StWrongState;
          end
        end
        KindClaim: begin
          if (phase[0] == PhReady) begin
            claimed = 1'b1;
          end else if (phase[1] == PhReady) begin
            claimed   = 1'b1;
            claim_idx = 1'b1;
          end
          if (claimed) phase[claim_idx] = PhWriting;
          else r.status = StNoneReady;
        end
        KindWriteDone: begin
          if (phase[sel] == PhWriting) phase[sel] = PhSyncing;
          else r.status = StWrongState;
        end
        KindRelease: begin
          if (phase[sel] == PhSyncing) begin
            phase[sel] = PhIdle;
            fill[sel]  = '0;
          end else begin
            r.status = StWrongState;
          end
        end
        KindSwitch: r.status = try_switch();
        default: r.status = StWrongState;
      endcase
      r.byte_offset     = offset[OffsetW-1:0];
      r.buffer_index    = claimed ? claim_idx : active;
      r.active_fill     = fill[active];
      r.active_sequence = stamp[active];
      return r;
    endfunction

    function void note_op(logic [2:0] kind, logic [16:0] req, logic sel);
      owed_replies.push_back(step_buffers(kind, req, sel));
      noted++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_replies.size() == 0) begin
        $error("result transaction with no operation outstanding");
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.byte_offset !== want.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
        mismatches++;
      end
      if (got.buffer_index !== want.buffer_index) begin
        $error("buffer_index: expected %0d, got %0d", want.buffer_index, got.buffer_index);
        mismatches++;
      end
      if (got.active_fill !== want.active_fill) begin
        $error("active_fill: expected %0d, got %0d", want.active_fill, got.active_fill);
        mismatches++;
      end
      if (got.active_sequence !== want.active_sequence) begin
        $error("active_sequence: expected %0d, got %0d", want.active_sequence,
               got.active_sequence);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Testbench top for the ping-pong buffer manager: stimulus, handshakes and checking.
module tb;
  import ppbm_pkg::*;
  import ppbm_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]        KindReserved6 = 3'd6;
  localparam logic [2:0]        KindReserved7 = 3'd7;
  localparam logic [PaddrW-1:0] ThresholdAddr = {CfgIdxThreshold, 2'b00};
  localparam int                WatchdogLimit = 1000;
  localparam int                OpsPerSetting = 120;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          kind_i;
  logic [16:0]         request_bytes_i;
  logic                buffer_select_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          status_o;
  logic [OffsetW-1:0]  byte_offset_o;
  logic                buffer_index_o;
  logic [FillOutW-1:0] active_fill_o;
  logic [SeqW-1:0]     active_sequence_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  buffer_scoreboard sb;
  logic             calm;
  int               quiet_cycles;
  int               settings_done;

  logic [ThresholdW-1:0] threshold_plan [9] = '{
    17'd1, 17'd300, 17'd4096, 17'd0, 17'd65535, 17'd65536, 17'd20000, 17'd61440, 17'h1FFFF
  };

  ping_pong_buffer_manager_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .request_bytes_i   (request_bytes_i),
    .buffer_select_i   (buffer_select_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .byte_offset_o     (byte_offset_o),
    .buffer_index_o    (buffer_index_o),
    .active_fill_o     (active_fill_o),
    .active_sequence_o (active_sequence_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  // Call right after a rising edge; returns at the edge that takes the transaction.
  task automatic send_op(logic [2:0] kind, logic [16:0] req, logic sel);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    request_bytes_i <= req;
    buffer_select_i <= sel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_op(kind, req, sel);
  endtask

  // Hold off the sender until every owed result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ThresholdW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ThresholdAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_threshold(value);
    settings_done++;
  endtask

  // Point write-done and release at a buffer in the phase they need, most of the time.
  function automatic logic aim_at(phase_e want);
    logic sel;
    sel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 6) != 0) begin
      if (sb.phase[0] == want) sel = 1'b0;
      if (sb.phase[1] == want && (sb.phase[0] != want || $urandom_range(0, 1) == 1)) sel = 1'b1;
    end
    return sel;
  endfunction

  // Receiver: draw a stall per result, then take the next one.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({status_o, byte_offset_o, buffer_index_o, active_fill_o,
                         active_sequence_o});
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned size_pick;
    logic [2:0]  op;
    logic [16:0] bytes;
    logic        sel;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    kind_i          = KindAcquire;
    request_bytes_i = '0;
    buffer_select_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = ThresholdAddr;
    pwdata          = '0;
    calm            = 1'b0;
    quiet_cycles    = 0;
    settings_done   = 0;
    sb              = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk one buffer through every phase, then overfill the other one.
    send_op(KindAcquire, 17'd0, 1'b0);
    send_op(KindAcquire, 17'h1FFFF, 1'b1);
    send_op(KindAcquire, 17'd65537, 1'b0);
    send_op(KindAcquire, 17'd4096, 1'b0);
    send_op(KindFlush, 17'd0, 1'b1);
    send_op(KindAcquire, 17'd16, 1'b0);
    send_op(KindFlush, 17'd0, 1'b0);
    send_op(KindSwitch, 17'd0, 1'b0);
    send_op(KindFlush, 17'd0, 1'b0);
    send_op(KindClaim, 17'd0, 1'b0);
    send_op(KindClaim, 17'd0, 1'b1);
    send_op(KindWriteDone, 17'd0, 1'b1);
    send_op(KindWriteDone, 17'd0, 1'b0);
    send_op(KindRelease, 17'd0, 1'b1);
    send_op(KindRelease, 17'd0, 1'b0);
    send_op(KindAcquire, 17'd61440, 1'b1);
    send_op(KindAcquire, 17'd0, 1'b0);
    send_op(KindAcquire, 17'd1, 1'b0);
    send_op(KindSwitch, 17'd0, 1'b1);
    send_op(KindReserved6, 17'd5, 1'b0);
    send_op(KindReserved7, 17'd5, 1'b1);
    send_op(KindClaim, 17'd0, 1'b0);
    drain();

    // Threshold above the buffer size: fill to the very end, offset wraps to zero.
    write_threshold(17'h1FFFF);
    send_op(KindWriteDone, 17'd0, 1'b0);
    send_op(KindRelease, 17'd0, 1'b0);
    send_op(KindSwitch, 17'd0, 1'b0);
    send_op(KindAcquire, 17'd65536, 1'b0);
    send_op(KindAcquire, 17'd0, 1'b1);
    drain();

    foreach (threshold_plan[p]) begin
      write_threshold(threshold_plan[p]);
      for (int n = 0; n < OpsPerSetting; n++) begin
        if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, 99);
        sel   = 1'($urandom_range(0, 1));
        bytes = 17'($urandom_range(0, 131071));
        if (pick < 50) begin
          op        = KindAcquire;
          size_pick = $urandom_range(0, 99);
          if (size_pick < 5) bytes = 17'($urandom_range(65537, 131071));
          else if (size_pick < 8) bytes = 17'd65536;
          else if (size_pick < 11) bytes = 17'd0;
          else if (size_pick < 50) bytes = 17'($urandom_range(1, 255));
          else if (size_pick < 80) bytes = 17'($urandom_range(256, 8191));
          else bytes = 17'($urandom_range(8192, 65535));
        end else if (pick < 57) begin
          op = KindFlush;
        end else if (pick < 69) begin
          op = KindClaim;
        end else if (pick < 79) begin
          op  = KindWriteDone;
          sel = aim_at(PhWriting);
        end else if (pick < 89) begin
          op  = KindRelease;
          sel = aim_at(PhSyncing);
        end else begin
          op = KindSwitch;
        end
        send_op(op, bytes, sel);
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    $display("tb: %0d operations sent and %0d results compared", sb.noted, sb.checked);
    $display("tb: %0d flush threshold settings, zero through the 17-bit maximum",
             settings_done);
    if (sb.mismatches == 0 && sb.owed_replies.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ppbm_pkg.sv
rtl/ppbm_step.sv
rtl/ping_pong_buffer_manager_top.sv
rtl/ppbm_checker.sv
tb/ppbm_scoreboard.sv
tb/tb.sv
